// ===== sv/slr_pkg.sv =====
// Shared types and constants for the scissored line rasterizer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

   localparam int COORD_BITS_DEFAULT = 13;
   localparam int QUEUE_DEPTH        = 4;
   localparam int SCISSOR_BITS       = 12;
   localparam int PITCH_BITS         = 13;
   localparam int ADDR_BITS          = 32;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCISSOR_LEFT   = 3'd0,
      CSR_SCISSOR_RIGHT  = 3'd1,
      CSR_SCISSOR_TOP    = 3'd2,
      CSR_SCISSOR_BOTTOM = 3'd3,
      CSR_ROW_PITCH      = 3'd4,
      CSR_FRAME_BASE     = 3'd5
   } slr_csr_index_type;

   localparam logic [SCISSOR_BITS-1:0] RESET_SCISSOR_LEFT   = 12'd0;
   localparam logic [SCISSOR_BITS-1:0] RESET_SCISSOR_RIGHT  = 12'd4095;
   localparam logic [SCISSOR_BITS-1:0] RESET_SCISSOR_TOP    = 12'd0;
   localparam logic [SCISSOR_BITS-1:0] RESET_SCISSOR_BOTTOM = 12'd4095;
   localparam logic [PITCH_BITS-1:0]   RESET_ROW_PITCH      = 13'd640;
   localparam logic [ADDR_BITS-1:0]    RESET_FRAME_BASE     = 32'd0;

   typedef struct packed {
      logic [SCISSOR_BITS-1:0] scissor_left;
      logic [SCISSOR_BITS-1:0] scissor_right;
      logic [SCISSOR_BITS-1:0] scissor_top;
      logic [SCISSOR_BITS-1:0] scissor_bottom;
      logic [PITCH_BITS-1:0]   row_pitch;
      logic [ADDR_BITS-1:0]    frame_base;
   } slr_cfg_type;

endpackage

`default_nettype wire

// ===== sv/slr_req_if.sv =====
// Request channel of the line rasterizer: load and step items.
// Depends on slr_pkg for the default coordinate width.
`timescale 1ns / 1ps
`default_nettype none

interface slr_req_if import slr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

// ===== sv/slr_rsp_if.sv =====
// Response channel of the line rasterizer: one pixel item per step.
// Depends on slr_pkg for the default coordinate width and address width.
`timescale 1ns / 1ps
`default_nettype none

interface slr_rsp_if import slr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic [ADDR_BITS-1:0]         pixel_address;
   logic                         write_enable;
   logic                         last;

   modport source (output valid, pixel_x, pixel_y, pixel_address, write_enable, last,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_address, write_enable, last,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/slr_stepper.sv =====
// Front part: accepts load and step items and runs the Bresenham stepper.
// Pushes pixel position items into the queue; depends on slr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slr_stepper import slr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic                         queue_full,
   output logic                         push,
   output logic [2*COORD_BITS:0]        push_data
);

   localparam int DW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 3;

   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [COORD_BITS-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [DW-1:0]         delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   logic                  dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic [EW-1:0]         error_ff, error_in;
   logic                  active_ff, active_in;

   logic signed [DW-1:0] dx, dy;
   logic [DW-1:0]        abs_dx, abs_dy;
   logic signed [EW:0]   e2, dx_ext, dy_ext;
   logic                 step_x, step_y, at_end, accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign at_end    = (pos_x_ff == goal_x_ff) && (pos_y_ff == goal_y_ff);
   assign push      = accept && (req_kind == KIND_STEP) && active_ff;
   assign push_data = {at_end, pos_y_ff, pos_x_ff};

   always_comb begin
      dx     = DW'(req_end_x) - DW'(req_start_x);
      dy     = DW'(req_end_y) - DW'(req_start_y);
      abs_dx = dx[DW-1] ? DW'(-dx) : DW'(dx);
      abs_dy = dy[DW-1] ? DW'(-dy) : DW'(dy);
      e2     = $signed({error_ff, 1'b0});
      dx_ext = $signed((EW+1)'(delta_x_ff));
      dy_ext = $signed((EW+1)'(delta_y_ff));
      step_x = e2 > -dy_ext;
      step_y = e2 < dx_ext;
   end

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      goal_x_in  = goal_x_ff;
      goal_y_in  = goal_y_ff;
      delta_x_in = delta_x_ff;
      delta_y_in = delta_y_ff;
      dir_x_in   = dir_x_ff;
      dir_y_in   = dir_y_ff;
      error_in   = error_ff;
      active_in  = active_ff;
      if (accept && (req_kind == KIND_LOAD)) begin
         pos_x_in   = req_start_x;
         pos_y_in   = req_start_y;
         goal_x_in  = req_end_x;
         goal_y_in  = req_end_y;
         delta_x_in = abs_dx;
         delta_y_in = abs_dy;
         dir_x_in   = !(req_start_x < req_end_x);
         dir_y_in   = !(req_start_y < req_end_y);
         error_in   = EW'(abs_dx) - EW'(abs_dy);
         active_in  = 1'b1;
      end else if (push) begin
         if (at_end) begin
            active_in = 1'b0;
         end else begin
            if (step_x) begin
               pos_x_in = pos_x_ff + (dir_x_ff ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
            end
            if (step_y) begin
               pos_y_in = pos_y_ff + (dir_y_ff ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
            end
            error_in = error_ff
                     + (step_y ? EW'(delta_x_ff) : EW'(0))
                     - (step_x ? EW'(delta_y_ff) : EW'(0));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff   <= pos_x_in;
      pos_y_ff   <= pos_y_in;
      goal_x_ff  <= goal_x_in;
      goal_y_ff  <= goal_y_in;
      delta_x_ff <= delta_x_in;
      delta_y_ff <= delta_y_in;
      dir_x_ff   <= dir_x_in;
      dir_y_ff   <= dir_y_in;
      error_ff   <= error_in;
   end

endmodule

`default_nettype wire

// ===== sv/slr_queue.sv =====
// Short register queue between the stepper and the pixel unit.
// Generic width and depth; depends on slr_pkg for the default width and depth.
`timescale 1ns / 1ps
`default_nettype none

module slr_queue import slr_pkg::*; #(
   parameter int WIDTH = 2 * COORD_BITS_DEFAULT + 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  pop;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] ptr);
      next_ptr = (ptr == PTR_BITS'(DEPTH - 1)) ? PTR_BITS'(0) : ptr + PTR_BITS'(1);
   endfunction

   assign full      = (count_ff == COUNT_BITS'(DEPTH));
   assign pop_valid = (count_ff != COUNT_BITS'(0));
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/slr_pixel_unit.sv =====
// Back part: scissor test and framebuffer address for each queued pixel.
// Two stages (row times pitch, then base add) with stall; depends on slr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slr_pixel_unit import slr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  slr_cfg_type                  cfg,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  logic [2*COORD_BITS:0]        pop_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [COORD_BITS-1:0] out_pixel_x,
   output logic signed [COORD_BITS-1:0] out_pixel_y,
   output logic [ADDR_BITS-1:0]         out_pixel_address,
   output logic                         out_write_enable,
   output logic                         out_last
);

   localparam int PW = COORD_BITS + PITCH_BITS + 1;
   localparam int CW = ((COORD_BITS > SCISSOR_BITS) ? COORD_BITS : SCISSOR_BITS) + 1;

   logic signed [COORD_BITS-1:0] in_x, in_y;
   logic                         in_last;
   logic signed [CW-1:0]         cmp_x, cmp_y;
   logic                         in_scissor;

   logic                         s1_valid_ff, s1_valid_in;
   logic signed [COORD_BITS-1:0] s1_x_ff, s1_y_ff;
   logic signed [PW-1:0]         s1_prod_ff, s1_prod_in;
   logic                         s1_inside_ff, s1_last_ff;

   logic                         s2_valid_ff, s2_valid_in;
   logic signed [COORD_BITS-1:0] s2_x_ff, s2_y_ff;
   logic [ADDR_BITS-1:0]         s2_addr_ff, s2_addr_in;
   logic                         s2_we_ff, s2_last_ff;
   logic [ADDR_BITS-1:0]         pixel_index;

   logic s2_load, s1_load;

   assign s2_load   = !s2_valid_ff || out_ready;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign pop_ready = s1_load;

   always_comb begin
      in_x       = $signed(pop_data[COORD_BITS-1:0]);
      in_y       = $signed(pop_data[2*COORD_BITS-1:COORD_BITS]);
      in_last    = pop_data[2*COORD_BITS];
      cmp_x      = CW'(in_x);
      cmp_y      = CW'(in_y);
      in_scissor = (cmp_x > $signed(CW'(cfg.scissor_left)))
                && (cmp_x < $signed(CW'(cfg.scissor_right)))
                && (cmp_y > $signed(CW'(cfg.scissor_top)))
                && (cmp_y < $signed(CW'(cfg.scissor_bottom)));
      s1_prod_in = PW'(in_y) * $signed(PW'(cfg.row_pitch));
      s1_valid_in = s1_load ? pop_valid : s1_valid_ff;
   end

   always_comb begin
      pixel_index = ADDR_BITS'(s1_prod_ff) + ADDR_BITS'(s1_x_ff);
      s2_addr_in  = cfg.frame_base + {pixel_index[ADDR_BITS-3:0], 2'b00};
      s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_x_ff      <= in_x;
         s1_y_ff      <= in_y;
         s1_prod_ff   <= s1_prod_in;
         s1_inside_ff <= in_scissor;
         s1_last_ff   <= in_last;
      end
      if (s2_load) begin
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_addr_ff <= s2_addr_in;
         s2_we_ff   <= s1_inside_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   assign out_valid         = s2_valid_ff;
   assign out_pixel_x       = s2_x_ff;
   assign out_pixel_y       = s2_y_ff;
   assign out_pixel_address = s2_addr_ff;
   assign out_write_enable  = s2_we_ff;
   assign out_last          = s2_last_ff;

endmodule

`default_nettype wire

// ===== sv/scissored_line_rasterizer.sv =====
// Top level of the scissored Bresenham line rasterizer.
// Depends on slr_pkg, slr_req_if, slr_rsp_if, slr_stepper, slr_queue, slr_pixel_unit.
//
// Usage:
//   req_chan carries items. kind = load takes both endpoints and sets up a
//   line; it gives no response. kind = step gives one pixel on rsp_chan while
//   a line is active, and nothing otherwise. A load replaces any active line.
//   csr_* writes the scissor bounds, row pitch and frame base; write only
//   while no item is in flight. Writes to unused indexes are dropped.
// Throughput: one item per cycle while the queue is not full; the stepper
//   registers its new error term and position with each accepted step, so steps may follow each other back to back.
// Path: an accepted step is written into the queue, then registered in the row
//   times pitch stage and in the column and base add stage before rsp_chan shows it.
// Stall: a four-entry queue sits between stepper and pixel unit; when rsp
//   is held off the pipeline holds, the queue fills, and req ready drops.
// Reset: synchronous; clears the line, the queue and the pipeline and sets
//   the registers to their defaults. ready is high the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module scissored_line_rasterizer import slr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   slr_req_if.sink                   req_chan,
   slr_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int ITEM_BITS = 2 * COORD_BITS + 1;

   slr_cfg_type cfg_ff, cfg_in;

   logic                 queue_full, push, pop_valid, pop_ready;
   logic [ITEM_BITS-1:0] push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (slr_csr_index_type'(csr_index))
            CSR_SCISSOR_LEFT:   cfg_in.scissor_left   = csr_write_data[SCISSOR_BITS-1:0];
            CSR_SCISSOR_RIGHT:  cfg_in.scissor_right  = csr_write_data[SCISSOR_BITS-1:0];
            CSR_SCISSOR_TOP:    cfg_in.scissor_top    = csr_write_data[SCISSOR_BITS-1:0];
            CSR_SCISSOR_BOTTOM: cfg_in.scissor_bottom = csr_write_data[SCISSOR_BITS-1:0];
            CSR_ROW_PITCH:      cfg_in.row_pitch      = csr_write_data[PITCH_BITS-1:0];
            CSR_FRAME_BASE:     cfg_in.frame_base     = csr_write_data[ADDR_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scissor_left   <= RESET_SCISSOR_LEFT;
         cfg_ff.scissor_right  <= RESET_SCISSOR_RIGHT;
         cfg_ff.scissor_top    <= RESET_SCISSOR_TOP;
         cfg_ff.scissor_bottom <= RESET_SCISSOR_BOTTOM;
         cfg_ff.row_pitch      <= RESET_ROW_PITCH;
         cfg_ff.frame_base     <= RESET_FRAME_BASE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slr_stepper #(
      .COORD_BITS (COORD_BITS)
   ) u_stepper (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_kind    (req_chan.kind),
      .req_start_x (req_chan.start_x),
      .req_start_y (req_chan.start_y),
      .req_end_x   (req_chan.end_x),
      .req_end_y   (req_chan.end_y),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   slr_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   slr_pixel_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_pixel_unit (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .out_valid         (rsp_chan.valid),
      .out_ready         (rsp_chan.ready),
      .out_pixel_x       (rsp_chan.pixel_x),
      .out_pixel_y       (rsp_chan.pixel_y),
      .out_pixel_address (rsp_chan.pixel_address),
      .out_write_enable  (rsp_chan.write_enable),
      .out_last          (rsp_chan.last)
   );

endmodule

`default_nettype wire

// ===== sv/slr_checker.sv =====
// Port-level assertions for scissored_line_rasterizer, attached by bind.
// Depends on slr_pkg and the top level's channel ports.
`timescale 1ns / 1ps
`default_nettype none

module slr_checker import slr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input logic                         rsp_write_enable
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready right after reset");

   a_we_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |->
         !rsp_pixel_x[COORD_BITS-1] && (rsp_pixel_x != '0) &&
         !rsp_pixel_y[COORD_BITS-1] && (rsp_pixel_y != '0))
      else $error("write enable on pixel outside the positive quadrant");

endmodule

bind scissored_line_rasterizer slr_checker #(
   .COORD_BITS (COORD_BITS)
) u_slr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_pixel_x      (rsp_chan.pixel_x),
   .rsp_pixel_y      (rsp_chan.pixel_y),
   .rsp_write_enable (rsp_chan.write_enable)
);

`default_nettype wire
